### hw/rtl/erq_pkg.sv
// Shared types and constants for the event ring queue.
`timescale 1ns / 1ps

package erq_pkg;

    // Default number of slots in the queue.
    localparam int DEF_QUEUE_DEPTH = 16;

    // Width of one stored event code.
    localparam int EVENT_W = 8;

    // Width of the operation code carried on the input tuser.
    localparam int OP_W = 2;

    // Bits of the result tuser: push_dropped, then pop_empty.
    localparam int OUT_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_TAIL = 2'd0,
        OP_PUSH_HEAD = 2'd1,
        OP_POP       = 2'd2,
        OP_FLUSH     = 2'd3
    } op_t;

    // Memory strobes and status flags for one operation.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic push_dropped;
        logic pop_empty;
    } erq_ctl_t;

endpackage

### hw/rtl/erq_ptr.sv
// Head, tail and occupancy registers of the event ring queue.
`timescale 1ns / 1ps

module erq_ptr #(
    parameter int QUEUE_DEPTH = erq_pkg::DEF_QUEUE_DEPTH,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH),
    parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_fire,
    input  erq_pkg::op_t     req_op,
    output erq_pkg::erq_ctl_t ctl,
    output logic [IDX_W-1:0] mem_addr,
    output logic [OCC_W-1:0] occupancy_next
);
    import erq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_CNT  = OCC_W'(QUEUE_DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] count_reg, count_next;
    logic             full;
    logic             empty;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_SLOT : idx - IDX_W'(1);
    endfunction

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ctl        = '0;
        mem_addr   = tail_reg;
        unique case (req_op)
            OP_PUSH_TAIL: begin
                if (full) begin
                    ctl.push_dropped = 1'b1;
                end else begin
                    ctl.wr_en  = 1'b1;
                    mem_addr   = tail_reg;
                    tail_next  = next_slot(tail_reg);
                    count_next = count_reg + OCC_W'(1);
                end
            end
            OP_PUSH_HEAD: begin
                if (full) begin
                    ctl.push_dropped = 1'b1;
                end else begin
                    // The new head slot is the one just before the current head.
                    ctl.wr_en  = 1'b1;
                    mem_addr   = prev_slot(head_reg);
                    head_next  = prev_slot(head_reg);
                    count_next = count_reg + OCC_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    ctl.pop_empty = 1'b1;
                end else begin
                    ctl.rd_en  = 1'b1;
                    mem_addr   = head_reg;
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - OCC_W'(1);
                end
            end
            OP_FLUSH: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default: begin
                head_next = head_reg;
            end
        endcase
    end

    assign occupancy_next = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (req_fire) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/event_ring_queue_with_push_front.sv
// Top level of the event ring queue with push at the head.
`timescale 1ns / 1ps

// The event ring queue stores byte-wide event codes in a circular buffer held
// in a synchronous memory with a registered read.
// Each request on the slave stream is one operation: the code on s_axis_tuser
// selects push at the tail, push at the head (served next), pop from the head
// or flush, and s_axis_tdata carries the event code for either push.
// Every request gives exactly one result on the master stream: the popped
// event (zero unless a pop succeeded) and the occupancy after the operation
// on m_axis_tdata, and the push-dropped and pop-empty flags on m_axis_tuser.
// A push into a full queue leaves it unchanged; a pop from an empty queue
// returns zero and leaves it unchanged.
// An accepted request first has its memory read and stage one registered,
// then moves to the output register, where its result becomes valid.
// One request can be accepted every cycle; the pointers and the occupancy are
// updated at acceptance, so a pop right after a push reads the written slot.
// When the receiver stalls, the output register holds its result and the
// read-data stage behind it fills; s_axis_tready then falls until the output
// moves on, so no result is ever lost or overwritten.
// Reset empties the queue and both pipeline stages and holds s_axis_tready low;
// the memory is not cleared, as a slot is only ever read after it was written.
module event_ring_queue_with_push_front #(
    parameter int QUEUE_DEPTH = erq_pkg::DEF_QUEUE_DEPTH,
    parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_DATA_W  = ((erq_pkg::EVENT_W + OCC_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [erq_pkg::EVENT_W-1:0]    s_axis_tdata,  // [7:0] event_value
    input  logic [erq_pkg::OP_W-1:0]       s_axis_tuser,  // [1:0] op
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_DATA_W-1:0]          m_axis_tdata,  // [7:0] popped_value,
                                                          // then occupancy,
                                                          // zero padding on top
    output logic [erq_pkg::OUT_USER_W-1:0] m_axis_tuser   // [0] push_dropped,
                                                          // [1] pop_empty
);
    import erq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    erq_ctl_t         ctl;
    logic [IDX_W-1:0] mem_addr;
    logic [OCC_W-1:0] occupancy_next;
    logic             req_fire;
    logic             s1_move;

    // Event storage, written and read at the address given by the pointers.
    logic [EVENT_W-1:0] event_mem [QUEUE_DEPTH];
    logic [EVENT_W-1:0] rd_data_reg;

    // Stage one: the operation's result while the memory read completes.
    logic             s1_valid_reg;
    logic             s1_pop_reg;
    logic [OCC_W-1:0] s1_occ_reg;
    logic             s1_dropped_reg;
    logic             s1_empty_reg;

    // Output register.
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_value_reg;
    logic [OCC_W-1:0]   out_occ_reg;
    logic               out_dropped_reg;
    logic               out_empty_reg;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = aresetn && (!s1_valid_reg || s1_move);
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    erq_ptr #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .OCC_W       (OCC_W)
    ) u_ptr (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_fire       (req_fire),
        .req_op         (op_t'(s_axis_tuser)),
        .ctl            (ctl),
        .mem_addr       (mem_addr),
        .occupancy_next (occupancy_next)
    );

    always_ff @(posedge aclk) begin
        if (req_fire && ctl.wr_en) begin
            event_mem[mem_addr] <= s_axis_tdata;
        end
    end

    // The read data stays put until the next pop is accepted, which cannot
    // happen while stage one still waits for the output register.
    always_ff @(posedge aclk) begin
        if (req_fire && ctl.rd_en) begin
            rd_data_reg <= event_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (req_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_fire) begin
            s1_pop_reg     <= ctl.rd_en;
            s1_occ_reg     <= occupancy_next;
            s1_dropped_reg <= ctl.push_dropped;
            s1_empty_reg   <= ctl.pop_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            out_value_reg   <= s1_pop_reg ? rd_data_reg : '0;
            out_occ_reg     <= s1_occ_reg;
            out_dropped_reg <= s1_dropped_reg;
            out_empty_reg   <= s1_empty_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_occ_reg, out_value_reg});
    assign m_axis_tuser  = {out_empty_reg, out_dropped_reg};

endmodule

### hw/rtl/erq_chk.sv
// Port-level checker for the event ring queue and its bind to the top level.
`timescale 1ns / 1ps

module erq_chk #(
    parameter int QUEUE_DEPTH = erq_pkg::DEF_QUEUE_DEPTH,
    parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_DATA_W  = ((erq_pkg::EVENT_W + OCC_W + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [erq_pkg::EVENT_W-1:0]    s_axis_tdata,
    input logic [erq_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [OUT_DATA_W-1:0]          m_axis_tdata,
    input logic [erq_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import erq_pkg::*;

    logic [EVENT_W-1:0] res_value;
    logic [OCC_W-1:0]   res_occ;
    logic               req_seen;

    assign res_value = m_axis_tdata[EVENT_W-1:0];
    assign res_occ   = m_axis_tdata[EVENT_W +: OCC_W];
    assign req_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

    // A held result keeps its contents until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The occupancy never exceeds the number of slots.
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // One operation cannot both drop a push and find the queue empty on a pop.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both status flags set");

    // A pop from an empty queue returns zero and leaves it empty.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> res_value == '0 && res_occ == '0)
        else $error("empty pop with data or occupancy");

    // A request accepted into an idle block shows its result once it has passed stage one and the output register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        req_seen && !m_axis_tvalid && $past(!s_axis_tvalid || !s_axis_tready)
            |=> ##1 m_axis_tvalid)
        else $error("result missing after two cycles");

endmodule

bind event_ring_queue_with_push_front erq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .OCC_W       (OCC_W),
    .OUT_DATA_W  (OUT_DATA_W)
) u_erq_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
